### hdl/cmfd_pkg.sv
// ---------------------------------------------------------------------------
// cmfd_pkg - shared types and codes of the call message frame decoder
// Result item layout, item kinds and header field type codes.
// ---------------------------------------------------------------------------
`default_nettype none

package cmfd_pkg;

	localparam int unsigned POS_W = 33;

	localparam logic [2:0] KIND_ID     = 3'd0;
	localparam logic [2:0] KIND_PATH   = 3'd1;
	localparam logic [2:0] KIND_DEST   = 3'd2;
	localparam logic [2:0] KIND_IFACE  = 3'd3;
	localparam logic [2:0] KIND_METHOD = 3'd4;
	localparam logic [2:0] KIND_PARAM  = 3'd5;
	localparam logic [2:0] KIND_END    = 3'd6;

	localparam logic [7:0] TYPE_PATH   = 8'h01;
	localparam logic [7:0] TYPE_IFACE  = 8'h02;
	localparam logic [7:0] TYPE_METHOD = 8'h03;
	localparam logic [7:0] TYPE_DEST   = 8'h06;
	localparam logic [7:0] TYPE_SIG    = 8'h09;

	localparam logic [POS_W-1:0] PREFIX_BYTES = 33'd16;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_HEADER,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic        emit;
		logic [2:0]  kind;
		logic [7:0]  text;
		logic        last;
		logic [7:0]  pidx;
		logic [31:0] id;
		logic [7:0]  count;
		logic        done;
	} res_t;

endpackage

`default_nettype wire

### hdl/cmfd_core.sv
// ---------------------------------------------------------------------------
// cmfd_core - per-byte decode step
// Message state registers and the single-pass logic that turns one byte
// into at most one result item and the next state.
// ---------------------------------------------------------------------------
`default_nettype none

module cmfd_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic [7:0]     b,
	output cmfd_pkg::res_t      res
);
	import cmfd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [31:0]        body_q, body_n;
	logic [POS_W-1:0]   hdr_q, hdr_n;
	logic [POS_W-1:0]   off_q, off_n;
	logic [7:0]         fkind_q, fkind_n;
	logic [31:0]        fsize_q, fsize_n;
	logic [7:0]         sig_q, sig_n;
	logic [7:0]         pnum_q, pnum_n;
	logic [31:0]        id_q, id_n;

	logic [3:0]         p;
	logic [31:0]        hdr_raw;
	logic [POS_W-1:0]   hdr_rnd;
	logic [POS_W-1:0]   region;
	logic [POS_W:0]     pos_inc;
	logic               prefix_end;
	logic               region_empty;
	logic               hdr_end;
	logic [POS_W-1:0]   str_end;
	logic [POS_W:0]     fs_round;
	logic [POS_W:0]     field_last;
	logic [2:0]         skind;
	logic               done;

	function automatic logic [2:0] string_kind(input logic [7:0] t);
		logic [2:0] k;
		case (t)
			TYPE_PATH:   k = KIND_PATH;
			TYPE_DEST:   k = KIND_DEST;
			TYPE_IFACE:  k = KIND_IFACE;
			TYPE_METHOD: k = KIND_METHOD;
			default:     k = KIND_ID;
		endcase
		return k;
	endfunction

	// Flags that steer the phase sequence.
	always_comb begin
		p = pos_q[3:0];
		hdr_raw = hdr_q[31:0];
		if (p >= 4'd12) begin
			hdr_raw[{p[1:0], 3'b000} +: 8] = b;
		end
		hdr_rnd = ({1'b0, hdr_raw} + 33'd7) & ~33'd7;
		region = (hdr_q >= PREFIX_BYTES) ? (hdr_q - PREFIX_BYTES) : '0;
		pos_inc = {1'b0, pos_q} + 34'd1;
		prefix_end = (phase_q == PH_PREFIX) && (p == 4'd15);
		region_empty = (hdr_rnd <= PREFIX_BYTES);
		hdr_end = (phase_q == PH_HEADER) && (pos_inc >= {1'b0, region});
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PREFIX: begin
				if (prefix_end) begin
					phase_d = region_empty ? PH_BODY : PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (hdr_end) begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: phase_d = PH_BODY;
			default: phase_d = PH_PREFIX;
		endcase
	end

	// Datapath and result.
	always_comb begin
		pos_n   = pos_inc[POS_W-1:0];
		body_n  = body_q;
		hdr_n   = hdr_q;
		off_n   = off_q + 33'd1;
		fkind_n = fkind_q;
		fsize_n = fsize_q;
		sig_n   = sig_q;
		pnum_n  = pnum_q;
		id_n    = id_q;
		res       = '0;
		res.kind  = KIND_ID;
		skind     = string_kind(fkind_q);
		str_end   = {1'b0, fsize_q} + 33'd8;
		fs_round  = {1'b0, {1'b0, fsize_q} + 33'd1} + 34'd7;
		field_last = {fs_round[POS_W:3], 3'b000} + 34'd7;
		case (phase_q)
			PH_PREFIX: begin
				if (p >= 4'd4 && p <= 4'd7) begin
					body_n[{p[1:0], 3'b000} +: 8] = b;
				end else if (p >= 4'd8 && p <= 4'd11) begin
					id_n[{p[1:0], 3'b000} +: 8] = b;
				end else if (p >= 4'd12) begin
					hdr_n = {1'b0, hdr_raw};
				end
				if (p == 4'd11) begin
					res.emit = 1'b1;
					res.kind = KIND_ID;
				end
				if (prefix_end) begin
					hdr_n = hdr_rnd;
					pos_n = '0;
					off_n = '0;
				end
			end
			PH_HEADER: begin
				if (off_q == '0) begin
					fkind_n = b;
				end else if (off_q[POS_W-1:2] == 31'd1) begin
					if (off_q[1:0] == 2'd0) begin
						fsize_n = {24'd0, b};
					end else if (fkind_q != TYPE_SIG) begin
						fsize_n[{off_q[1:0], 3'b000} +: 8] = b;
					end
					if (off_q[1:0] == 2'd3 && fkind_q == TYPE_SIG) begin
						sig_n = fsize_q[7:0];
					end
				end else if (off_q >= 33'd8 && off_q <= str_end) begin
					if (skind != KIND_ID) begin
						res.emit = 1'b1;
						res.kind = skind;
						res.text = b;
						res.last = (off_q == str_end);
					end
				end
				// restart the field offset after the padded string
				if (off_q >= 33'd8 && {1'b0, off_q} == field_last) begin
					off_n = '0;
				end
				if (hdr_end) begin
					pos_n  = '0;
					off_n  = '0;
					pnum_n = '0;
				end
			end
			PH_BODY: begin
				if (sig_q != 8'd0) begin
					if (off_q < 33'd4) begin
						if (off_q[1:0] == 2'd0) begin
							fsize_n = {24'd0, b};
						end else begin
							fsize_n[{off_q[1:0], 3'b000} +: 8] = b;
						end
					end else begin
						res.emit = 1'b1;
						res.kind = KIND_PARAM;
						res.text = b;
						res.pidx = pnum_q;
						if (off_q == {1'b0, fsize_q} + 33'd4) begin
							res.last = 1'b1;
							pnum_n   = pnum_q + 8'd1;
							off_n    = '0;
						end
					end
				end
			end
			default: begin
				pos_n = '0;
				off_n = '0;
			end
		endcase
		done = (phase_d == PH_BODY) && (pos_n >= {1'b0, body_q});
		if (done && !res.emit) begin
			res.emit = 1'b1;
			res.kind = KIND_END;
			res.text = 8'd0;
			res.last = 1'b0;
			res.pidx = 8'd0;
		end
		res.id    = id_n;
		res.count = sig_n;
		res.done  = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= '0;
			body_q  <= '0;
			hdr_q   <= '0;
			off_q   <= '0;
			fkind_q <= '0;
			fsize_q <= '0;
			sig_q   <= '0;
			pnum_q  <= '0;
			id_q    <= '0;
		end else if (en) begin
			if (done) begin
				// clear everything: the next byte opens a new message
				phase_q <= PH_PREFIX;
				pos_q   <= '0;
				body_q  <= '0;
				hdr_q   <= '0;
				off_q   <= '0;
				fkind_q <= '0;
				fsize_q <= '0;
				sig_q   <= '0;
				pnum_q  <= '0;
				id_q    <= '0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_n;
				body_q  <= body_n;
				hdr_q   <= hdr_n;
				off_q   <= off_n;
				fkind_q <= fkind_n;
				fsize_q <= fsize_n;
				sig_q   <= sig_n;
				pnum_q  <= pnum_n;
				id_q    <= id_n;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/call_message_frame_decoder.sv
// ---------------------------------------------------------------------------
// call_message_frame_decoder - streaming method-call message decoder
// Takes message bytes one per item and emits the id, the header strings and
// the body parameter strings, flagging the last byte of each message.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ----------------------------------
//  in       in   in_valid / in_ready    msg_byte
//  out      out  out_valid / out_ready  item_kind, text_byte, last_of_string,
//                                       param_index, msg_id,
//                                       param_count, message_done
//
// One byte per cycle sustained while the result is not stalled; a taken byte
// is decoded from the input register into the result register.
// Reset returns the decoder to the message prefix; no clearing pass.
// A stalled result holds the decode stage, and the input register takes at
// most one more byte before in_ready drops.
`default_nettype none

module call_message_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  msg_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       item_kind,
	output logic [7:0]       text_byte,
	output logic             last_of_string,
	output logic [7:0]       param_index,
	output logic [31:0]      msg_id,
	output logic [7:0]       param_count,
	output logic             message_done
);
	import cmfd_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       out_valid_q;
	res_t       res;
	res_t       res_q;

	assign adv      = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= msg_byte;
		end
	end

	cmfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.b      (byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign item_kind      = res_q.kind;
	assign text_byte      = res_q.text;
	assign last_of_string = res_q.last;
	assign param_index    = res_q.pidx;
	assign msg_id         = res_q.id;
	assign param_count    = res_q.count;
	assign message_done   = res_q.done;

	a_end_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_END |-> message_done)
		else $error("end marker without message_done");

	a_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_ID || item_kind == KIND_END)
		|-> !last_of_string && text_byte == 8'd0)
		else $error("id or end item carries text");

	a_pidx_param_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_PARAM |-> param_index == 8'd0)
		else $error("param_index set outside body parameter");

	a_stall_holds_core: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !adv)
		else $error("decode advanced into a stalled result");

endmodule

`default_nettype wire
